// ===== rtl/tbcp_pkg.sv =====
// ============================================================================
// tbcp_pkg: shared constants and types for the ten-bit coefficient packer
// Sizes of the polynomial and packed format, field widths, direction and
// step codes, and the structs passed between the datapath modules.
// ============================================================================
package tbcp_pkg;

    localparam int NUM_COEFFS   = 256;
    localparam int GROUP_STRIDE = 16;
    localparam int WORD_COUNT   = NUM_COEFFS / 8;
    localparam int BLOCK_SPAN   = 8 * GROUP_STRIDE;
    localparam int TOTAL_BYTES  = NUM_COEFFS + 2 * WORD_COUNT;

    localparam int POS_W   = $clog2(TOTAL_BYTES);
    localparam int COEFF_W = $clog2(NUM_COEFFS);
    localparam int WORD_W  = $clog2(WORD_COUNT);
    localparam int J_W     = $clog2(GROUP_STRIDE);
    localparam int GROUP_W = 3;
    localparam int STEP_W  = 3;
    localparam int DATA_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 9;
    localparam int PAIR_LSB = 6;

    localparam logic [GROUP_W-1:0] LAST_GROUP = 3'd7;

    // direction register codes
    localparam logic DIR_PACK   = 1'b0;
    localparam logic DIR_UNPACK = 1'b1;

    // result steps of one item
    localparam logic [STEP_W-1:0] PSTEP_COEFF   = 3'd0;
    localparam logic [STEP_W-1:0] PSTEP_WORD_LO = 3'd1;
    localparam logic [STEP_W-1:0] PSTEP_WORD_HI = 3'd2;
    localparam logic [STEP_W-1:0] USTEP_LAST    = 3'd7;

    // decode of the item at the current position
    typedef struct packed {
        logic [COEFF_W-1:0] c;      // coefficient index (pack)
        logic [WORD_W-1:0]  w;      // low word index (pack)
        logic [GROUP_W-1:0] k;      // pair slot within the word (pack)
        logic               done;   // item closes the polynomial
        logic               hi_wr;  // unpack: high byte section
        logic               lo_odd; // unpack: second byte of a low word
        logic [COEFF_W-1:0] ubase;  // unpack: coefficient of slot 0 of the word
    } item_t;

    // read-modify-write request to the low word store
    typedef struct packed {
        logic [WORD_W-1:0]  w;
        logic [GROUP_W-1:0] k;
        logic [1:0]         pair;
    } low_upd_t;

endpackage

// ===== rtl/tbcp_if.sv =====
// ============================================================================
// tbcp_if: valid/ready channels of the ten-bit coefficient packer
// Input item channel, result channel and direction write channel.
// ============================================================================
interface tbcp_in_if import tbcp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_in;

    modport source (output valid, output data_in, input ready);
    modport sink   (input valid, input data_in, output ready);
endinterface

interface tbcp_out_if import tbcp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] out_value;
    logic [IDX_W-1:0]  out_index;
    logic              run_last;
    logic              poly_done;

    modport source (output valid, output out_value, output out_index,
                    output run_last, output poly_done, input ready);
    modport sink   (input valid, input out_value, input out_index,
                    input run_last, input poly_done, output ready);
endinterface

interface tbcp_cfg_if ();
    logic valid;
    logic ready;
    logic direction;

    modport source (output valid, output direction, input ready);
    modport sink   (input valid, input direction, output ready);
endinterface

// ===== rtl/ten_bit_coeff_pack_unpack.sv =====
// ============================================================================
// ten_bit_coeff_pack_unpack: ten-bit polynomial coefficient packer/unpacker
// Flow: an item's results pass through the job registers and then the output
// register, leaving at one per cycle while dout is not stalled; a new item is
// taken as the last result of the one in work leaves. Pack: one result per
// coefficient, three on the last coefficient of each low word (320 results per
// polynomial). Unpack: eight results on the second byte of each low word, else none.
// Reset: direction returns to pack, position zero, no results pending;
// the word and byte stores are not cleared and need no clearing pass.
// ============================================================================
module ten_bit_coeff_pack_unpack import tbcp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    tbcp_cfg_if.sink    cfg,
    tbcp_in_if.sink     din,
    tbcp_out_if.source  dout
);

    // Direction register. Any write restarts the polynomial.
    logic direction_reg, direction_next;
    logic cfg_wr;

    // Per-item decode and handshake between the blocks
    item_t              item;
    logic               accept;
    logic               in_ready;

    // Pack side: low word read-modify-write
    logic               low_rd_en;
    logic               low_upd_en;
    low_upd_t           low_upd;
    logic [DATA_W-1:0]  low_word;

    // Unpack side: high byte store
    logic               hi_wr_en;
    logic               hi_rd_en;
    logic [COEFF_W-1:0] hi_rd_addr;
    logic [BYTE_W-1:0]  hi_byte;

    // Config never stalls; the user writes only while the block is idle, unchecked.
    assign cfg.ready      = 1'b1;
    assign cfg_wr         = cfg.valid && cfg.ready;
    assign direction_next = cfg_wr ? cfg.direction : direction_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_PACK;
        end
        else
        begin
            direction_reg <= direction_next;
        end
    end

    assign din.ready = in_ready;

    // Read the word being built as the coefficient is taken; the merge and
    // write back happen in the sequencer's first cycle for that item.
    assign low_rd_en = accept && (direction_reg == DIR_PACK);

    // Store each high byte as it arrives in the first section of the stream.
    assign hi_wr_en  = accept && (direction_reg == DIR_UNPACK) && item.hi_wr;

    tbcp_pos_ctl u_pos_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .restart   (cfg_wr),
        .direction (direction_reg),
        .item      (item)
    );

    tbcp_low_store u_low_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (low_rd_en),
        .rd_addr  (item.w),
        .upd_en   (low_upd_en),
        .upd      (low_upd),
        .upd_word (low_word)
    );

    tbcp_high_store u_high_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (hi_wr_en),
        .wr_addr (item.c),
        .wr_data (din.data_in[BYTE_W-1:0]),
        .rd_en   (hi_rd_en),
        .rd_addr (hi_rd_addr),
        .rd_data (hi_byte)
    );

    // Sequencer: hold the item in work, advance one result per cycle into
    // the output register while it can take one, drop the item after its last result.
    tbcp_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (cfg_wr),
        .direction  (direction_reg),
        .in_valid   (din.valid),
        .data_in    (din.data_in),
        .item       (item),
        .low_word   (low_word),
        .hi_byte    (hi_byte),
        .in_ready   (in_ready),
        .accept     (accept),
        .low_upd_en (low_upd_en),
        .low_upd    (low_upd),
        .hi_rd_en   (hi_rd_en),
        .hi_rd_addr (hi_rd_addr),
        .dout       (dout)
    );

endmodule

// ===== rtl/tbcp_pos_ctl.sv =====
// ============================================================================
// tbcp_pos_ctl: position tracking
// Keeps the item position in the polynomial and the word/group counters
// for both directions, and decodes the item at the current position.
// ============================================================================
module tbcp_pos_ctl import tbcp_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  logic  restart,
    input  logic  direction,
    output item_t item
);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [J_W-1:0]     pj_reg, pj_next;
    logic [GROUP_W-1:0] pk_reg, pk_next;
    logic [WORD_W-1:0]  pwb_reg, pwb_next;
    logic [J_W-1:0]     uj_reg, uj_next;
    logic [COEFF_W-1:0] ub_reg, ub_next;

    always_comb
    begin
        item.c      = pos_reg[COEFF_W-1:0];
        item.w      = pwb_reg + WORD_W'(pj_reg);
        item.k      = pk_reg;
        item.done   = (direction == DIR_PACK) ? (pos_reg == POS_W'(NUM_COEFFS - 1))
                                              : (pos_reg == POS_W'(TOTAL_BYTES - 1));
        item.hi_wr  = pos_reg < POS_W'(NUM_COEFFS);
        item.lo_odd = !item.hi_wr && pos_reg[0];
        item.ubase  = ub_reg;
    end

    always_comb
    begin
        pos_next = pos_reg;
        pj_next  = pj_reg;
        pk_next  = pk_reg;
        pwb_next = pwb_reg;
        uj_next  = uj_reg;
        ub_next  = ub_reg;
        if (restart || (accept && item.done))
        begin
            pos_next = '0;
            pj_next  = '0;
            pk_next  = '0;
            pwb_next = '0;
            uj_next  = '0;
            ub_next  = '0;
        end
        else if (accept)
        begin
            pos_next = pos_reg + POS_W'(1);
            if (direction == DIR_PACK)
            begin
                // walk j fastest, then k, then the block of words
                if (pj_reg == J_W'(GROUP_STRIDE - 1))
                begin
                    pj_next = '0;
                    if (pk_reg == LAST_GROUP)
                    begin
                        pk_next  = '0;
                        pwb_next = pwb_reg + WORD_W'(GROUP_STRIDE);
                    end
                    else
                    begin
                        pk_next = pk_reg + GROUP_W'(1);
                    end
                end
                else
                begin
                    pj_next = pj_reg + J_W'(1);
                end
            end
            else if (item.lo_odd)
            begin
                if (uj_reg == J_W'(GROUP_STRIDE - 1))
                begin
                    uj_next = '0;
                    ub_next = ub_reg + COEFF_W'(BLOCK_SPAN - GROUP_STRIDE + 1);
                end
                else
                begin
                    uj_next = uj_reg + J_W'(1);
                    ub_next = ub_reg + COEFF_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            pj_reg  <= '0;
            pk_reg  <= '0;
            pwb_reg <= '0;
            uj_reg  <= '0;
            ub_reg  <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            pj_reg  <= pj_next;
            pk_reg  <= pk_next;
            pwb_reg <= pwb_next;
            uj_reg  <= uj_next;
            ub_reg  <= ub_next;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg < POS_W'(TOTAL_BYTES)) &&
        ((direction == DIR_UNPACK) || (pos_reg < POS_W'(NUM_COEFFS))))
        else $error("position outside the polynomial");

endmodule

// ===== rtl/tbcp_low_store.sv =====
// ============================================================================
// tbcp_low_store: low word store for packing
// Synchronous memory of partial low words. Read at item acceptance, merge
// the coefficient's bit pair in the next cycle and write back; a finished
// word is written back as zero.
// ============================================================================
module tbcp_low_store import tbcp_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [WORD_W-1:0] rd_addr,
    input  logic              upd_en,
    input  low_upd_t          upd,
    output logic [DATA_W-1:0] upd_word
);

    logic [DATA_W-1:0] word_mem [WORD_COUNT];
    logic [DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0] base_word;
    logic [DATA_W-1:0] pair_bits;
    logic [DATA_W-1:0] wr_data;

    always_comb
    begin
        // the first group of a word starts it fresh, so stale entries never leak
        base_word = (upd.k == '0) ? '0 : rd_data_reg;
        pair_bits = DATA_W'(upd.pair) << (4'd14 - {upd.k, 1'b0});
        upd_word  = base_word | pair_bits;
        wr_data   = (upd.k == LAST_GROUP) ? '0 : upd_word;
    end

    always_ff @(posedge clk)
    begin
        if (upd_en)
        begin
            word_mem[upd.w] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= (upd_en && (upd.w == rd_addr)) ? wr_data : word_mem[rd_addr];
        end
    end

    a_upd_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        upd_en |-> ($past(rd_en) && ($past(rd_addr) == upd.w)))
        else $error("low word update without its read");

    a_no_same_word: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_en && rd_en) |-> (rd_addr != upd.w))
        else $error("back-to-back coefficients share a low word");

endmodule

// ===== rtl/tbcp_high_store.sv =====
// ============================================================================
// tbcp_high_store: high byte store for unpacking
// Synchronous memory of the high bytes of one polynomial, one write and
// one registered read port.
// ============================================================================
module tbcp_high_store import tbcp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [COEFF_W-1:0] wr_addr,
    input  logic [BYTE_W-1:0]  wr_data,
    input  logic               rd_en,
    input  logic [COEFF_W-1:0] rd_addr,
    output logic [BYTE_W-1:0]  rd_data
);

    logic [BYTE_W-1:0] byte_mem [NUM_COEFFS];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byte_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= byte_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

    a_no_write_during_read: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !rd_en)
        else $error("high byte written while a word is being expanded");

endmodule

// ===== rtl/tbcp_emit.sv =====
// ============================================================================
// tbcp_emit: result sequencer
// Holds the item in work, steps through its results one per cycle while the
// result channel is not stalled, and drives the registered result channel.
// ============================================================================
module tbcp_emit import tbcp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               restart,
    input  logic               direction,
    input  logic               in_valid,
    input  logic [DATA_W-1:0]  data_in,
    input  item_t              item,
    input  logic [DATA_W-1:0]  low_word,
    input  logic [BYTE_W-1:0]  hi_byte,
    output logic               in_ready,
    output logic               accept,
    output logic               low_upd_en,
    output low_upd_t           low_upd,
    output logic               hi_rd_en,
    output logic [COEFF_W-1:0] hi_rd_addr,
    tbcp_out_if.source         dout
);

    logic               job_valid_reg, job_valid_next;
    logic [STEP_W-1:0]  job_step_reg, job_step_next;
    logic [COEFF_W-1:0] job_c_reg, job_c_next;
    logic [BYTE_W-1:0]  job_hi_reg, job_hi_next;
    logic [WORD_W-1:0]  job_w_reg, job_w_next;
    logic [GROUP_W-1:0] job_k_reg, job_k_next;
    logic [1:0]         job_pair_reg, job_pair_next;
    logic               job_done_reg, job_done_next;
    logic               job_fresh_reg, job_fresh_next;
    logic [DATA_W-1:0]  job_word_reg, job_word_next;
    logic [BYTE_W-1:0]  held_reg, held_next;

    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_value_reg;
    logic [IDX_W-1:0]   out_index_reg;
    logic               out_last_reg;
    logic               out_done_reg;

    logic               out_adv;
    logic [STEP_W-1:0]  last_step;
    logic               job_last;
    logic               emit;
    logic               load;
    logic [POS_W-1:0]   byte_pos;
    logic [DATA_W-1:0]  res_value;
    logic [IDX_W-1:0]   res_index;

    always_comb
    begin
        out_adv   = !out_valid_reg || dout.ready;
        if (direction == DIR_UNPACK)
        begin
            last_step = USTEP_LAST;
        end
        else
        begin
            last_step = (job_k_reg == LAST_GROUP) ? PSTEP_WORD_HI : PSTEP_COEFF;
        end
        job_last  = job_step_reg == last_step;
        emit      = job_valid_reg && out_adv;
        in_ready  = !job_valid_reg || (emit && job_last);
        accept    = in_valid && in_ready;
        load      = accept && ((direction == DIR_PACK) || item.lo_odd);
    end

    // result of the current step
    always_comb
    begin
        byte_pos = POS_W'(NUM_COEFFS)
                 + POS_W'({job_w_reg, job_step_reg == PSTEP_WORD_HI});
        res_value = '0;
        res_index = IDX_W'(job_c_reg);
        if (direction == DIR_UNPACK)
        begin
            res_value = {hi_byte, job_word_reg[DATA_W-1 -: 2], {PAIR_LSB{1'b0}}};
        end
        else
        begin
            case (job_step_reg)
                PSTEP_COEFF:
                begin
                    res_value = {{BYTE_W{1'b0}}, job_hi_reg};
                end
                PSTEP_WORD_LO:
                begin
                    res_value = {{BYTE_W{1'b0}}, job_word_reg[BYTE_W-1:0]};
                    res_index = IDX_W'(byte_pos);
                end
                default:
                begin
                    res_value = {{BYTE_W{1'b0}}, job_word_reg[DATA_W-1:BYTE_W]};
                    res_index = IDX_W'(byte_pos);
                end
            endcase
        end
    end

    always_comb
    begin
        job_valid_next = job_valid_reg;
        job_step_next  = job_step_reg;
        job_c_next     = job_c_reg;
        job_hi_next    = job_hi_reg;
        job_w_next     = job_w_reg;
        job_k_next     = job_k_reg;
        job_pair_next  = job_pair_reg;
        job_done_next  = job_done_reg;
        job_word_next  = job_word_reg;
        job_fresh_next = 1'b0;
        held_next      = held_reg;

        // latch the merged low word on the cycle it is written back
        if (job_fresh_reg)
        begin
            job_word_next = low_word;
        end

        if (emit)
        begin
            if (job_last)
            begin
                job_valid_next = 1'b0;
            end
            else
            begin
                job_step_next = job_step_reg + STEP_W'(1);
                if (direction == DIR_UNPACK)
                begin
                    job_c_next    = job_c_reg + COEFF_W'(GROUP_STRIDE);
                    job_word_next = {job_word_reg[DATA_W-3:0], 2'b00};
                end
            end
        end

        if (load)
        begin
            job_valid_next = 1'b1;
            job_step_next  = '0;
            job_done_next  = item.done;
            job_hi_next    = data_in[DATA_W-1:BYTE_W];
            job_w_next     = item.w;
            job_k_next     = item.k;
            job_pair_next  = data_in[PAIR_LSB +: 2];
            if (direction == DIR_PACK)
            begin
                job_c_next     = item.c;
                job_fresh_next = 1'b1;
            end
            else
            begin
                job_c_next    = item.ubase;
                job_word_next = {data_in[BYTE_W-1:0], held_reg};
            end
        end

        if (accept && (direction == DIR_UNPACK) && !item.hi_wr && !item.lo_odd)
        begin
            held_next = data_in[BYTE_W-1:0];
        end
        if (restart)
        begin
            held_next = '0;
        end
    end

    // high byte read tracks the step that is current after this edge
    assign hi_rd_en   = job_valid_next && (direction == DIR_UNPACK);
    assign hi_rd_addr = job_c_next;

    assign low_upd_en = job_fresh_reg;
    assign low_upd    = '{w: job_w_reg, k: job_k_reg, pair: job_pair_reg};

    assign out_valid_next = emit ? 1'b1 : (dout.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            job_fresh_reg <= 1'b0;
            job_step_reg  <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            job_fresh_reg <= job_fresh_next;
            job_step_reg  <= job_step_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_c_reg    <= job_c_next;
        job_hi_reg   <= job_hi_next;
        job_w_reg    <= job_w_next;
        job_k_reg    <= job_k_next;
        job_pair_reg <= job_pair_next;
        job_done_reg <= job_done_next;
        job_word_reg <= job_word_next;
        if (emit)
        begin
            out_value_reg <= res_value;
            out_index_reg <= res_index;
            out_last_reg  <= job_last;
            out_done_reg  <= job_last && job_done_reg;
        end
    end

    assign dout.valid     = out_valid_reg;
    assign dout.out_value = out_value_reg;
    assign dout.out_index = out_index_reg;
    assign dout.run_last  = out_last_reg;
    assign dout.poly_done = out_done_reg;

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_done_reg) |-> out_last_reg)
        else $error("polynomial end flagged on a non-final result");

    a_fresh_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        job_fresh_reg |-> (job_valid_reg && (job_step_reg == PSTEP_COEFF) && $past(load)))
        else $error("low word merge outside the first cycle of a pack item");

endmodule
